FILE: hdl/lpps_pkg.sv
package lpps_pkg;

	// square root: two result bits per stage over a 64-bit radicand
	localparam int SQ_STEPS  = 2;
	localparam int SQ_STAGES = 32 / SQ_STEPS;
	// rounded quotient for unit vector components
	localparam int DV_BITS   = 18;
	localparam int DV_STEPS  = 3;
	localparam int DV_STAGES = DV_BITS / DV_STEPS;
	// input reg, squares, sum, sqrt stages, divide stages, clamp
	localparam int UNIT_LAT  = 4 + SQ_STAGES + DV_STAGES;

	localparam logic [15:0] Q14_ONE = 16'd16384;
	localparam logic [63:0] POW_CAP = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [47:0] view;
		logic [47:0] light;
		logic [15:0] inten;
		logic [47:0] surf;
		logic [15:0] spec;
		logic [15:0] shade;
		logic        emit;
	} side_t;

	// round to nearest, ties away from zero, then drop k fraction bits
	function automatic logic signed [63:0] rnd_s(input logic signed [63:0] x,
		input logic [5:0] k);
		logic [63:0] mag;
		logic [63:0] q;
		mag = x[63] ? 64'(-x) : 64'(x);
		q = (mag + (64'd1 << (k - 6'd1))) >> k;
		return x[63] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [63:0] rnd_u(input logic [63:0] x, input logic [5:0] k);
		return (x + (64'd1 << (k - 6'd1))) >> k;
	endfunction

endpackage

FILE: hdl/lpps_unit3.sv
module lpps_unit3 import lpps_pkg::*; #(
	parameter int W = 17
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] vec [3],
	output logic signed [15:0]  unit_vec [3]
);

	logic signed [W-1:0] c_s1 [3];
	logic signed [W-1:0] c_s2 [3];
	logic signed [W-1:0] c_s3 [3];
	logic [2*W-1:0]      sq_s2 [3];
	logic [63:0]         x_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i]  <= vec[i];
				c_s2[i]  <= c_s1[i];
				sq_s2[i] <= (2*W)'(c_s1[i] * c_s1[i]);
				c_s3[i]  <= c_s2[i];
			end
			x_s3 <= (64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2])) << 28;
		end
	end

	// floor square root, restoring form
	logic [63:0]         rem_sq  [SQ_STAGES];
	logic [63:0]         root_sq [SQ_STAGES];
	logic signed [W-1:0] c_sq    [SQ_STAGES][3];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
		logic [63:0]         rem_in, root_in, rem_nx, root_nx, trial, bitv;
		logic signed [W-1:0] c_in [3];
		if (g == 0) begin : g_first
			assign rem_in  = x_s3;
			assign root_in = '0;
			assign c_in    = c_s3;
		end else begin : g_next
			assign rem_in  = rem_sq[g-1];
			assign root_in = root_sq[g-1];
			assign c_in    = c_sq[g-1];
		end
		always_comb begin
			rem_nx  = rem_in;
			root_nx = root_in;
			trial   = '0;
			bitv    = '0;
			for (int j = 0; j < SQ_STEPS; j++) begin
				bitv  = 64'd1 << 6'(62 - 2 * (g * SQ_STEPS + j));
				trial = root_nx + bitv;
				if (rem_nx >= trial) begin
					rem_nx  = rem_nx - trial;
					root_nx = (root_nx >> 1) + bitv;
				end else begin
					root_nx = root_nx >> 1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sq[g]  <= rem_nx;
				root_sq[g] <= root_nx;
				c_sq[g]    <= c_in;
			end
		end
	end

	// (|c| * 2^28 + len/2) / len, one quotient bit per step
	logic [63:0]        rem_dv [DV_STAGES][3];
	logic [DV_BITS-1:0] q_dv   [DV_STAGES][3];
	logic [2:0]         neg_dv [DV_STAGES];
	logic [31:0]        den_dv [DV_STAGES];
	logic               zero_dv [DV_STAGES];

	for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
		logic [63:0]        rem_in [3];
		logic [DV_BITS-1:0] q_in   [3];
		logic [2:0]         neg_in;
		logic [31:0]        den_in;
		logic               zero_in;
		logic [63:0]        rem_nx [3];
		logic [DV_BITS-1:0] q_nx   [3];
		logic [63:0]        dsh;
		if (g == 0) begin : g_first
			logic signed [63:0] cw;
			logic [63:0]        mag;
			assign den_in  = root_sq[SQ_STAGES-1][31:0];
			assign zero_in = (den_in == 32'd0);
			always_comb begin
				cw  = '0;
				mag = '0;
				for (int i = 0; i < 3; i++) begin
					cw        = 64'(c_sq[SQ_STAGES-1][i]);
					mag       = cw[63] ? 64'(-cw) : 64'(cw);
					neg_in[i] = cw[63];
					rem_in[i] = (mag << 28) + 64'(den_in >> 1);
					q_in[i]   = '0;
				end
			end
		end else begin : g_next
			assign rem_in  = rem_dv[g-1];
			assign q_in    = q_dv[g-1];
			assign neg_in  = neg_dv[g-1];
			assign den_in  = den_dv[g-1];
			assign zero_in = zero_dv[g-1];
		end
		always_comb begin
			dsh = '0;
			for (int i = 0; i < 3; i++) begin
				rem_nx[i] = rem_in[i];
				q_nx[i]   = q_in[i];
				for (int j = 0; j < DV_STEPS; j++) begin
					dsh = 64'(den_in) << 6'(DV_BITS - 1 - (g * DV_STEPS + j));
					if (rem_nx[i] >= dsh) begin
						rem_nx[i] = rem_nx[i] - dsh;
						q_nx[i]   = q_nx[i] |
							(DV_BITS'(1) << 5'(DV_BITS - 1 - (g * DV_STEPS + j)));
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_dv[g]  <= rem_nx;
				q_dv[g]    <= q_nx;
				neg_dv[g]  <= neg_in;
				den_dv[g]  <= den_in;
				zero_dv[g] <= zero_in;
			end
		end
	end

	logic [15:0] qc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (q_dv[DV_STAGES-1][i] > DV_BITS'(Q14_ONE)) ? Q14_ONE
				: q_dv[DV_STAGES-1][i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_dv[DV_STAGES-1])
					unit_vec[i] <= '0;
				else if (neg_dv[DV_STAGES-1][i])
					unit_vec[i] <= -$signed(qc[i]);
				else
					unit_vec[i] <= $signed(qc[i]);
			end
		end
	end

endmodule

FILE: hdl/lambert_phong_point_shader.sv
// Throughput: one request per cycle while the result is not stalled; three unit-vector
// pipes (26 stages each: a 16-stage square root and a 6-stage divider) and one multiply
// stage per power step set the depth. A stalled result freezes the whole pipe; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears the valid bits only; data registers are not reset.
module lambert_phong_point_shader import lpps_pkg::*; #(
	parameter int SHININESS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] hit_position,
	input  logic [47:0] surface_normal,
	input  logic [47:0] view_direction,
	input  logic [47:0] light_position,
	input  logic [47:0] light_rgb,
	input  logic [15:0] light_intensity,
	input  logic [47:0] surface_rgb,
	input  logic [15:0] specular_strength,
	input  logic [15:0] shade_factor,
	input  logic        is_emitter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] shaded_rgb
);

	localparam int TOTAL = 2 * UNIT_LAT + SHININESS + 6;

	logic             en;
	logic [TOTAL-1:0] vld_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL-2:0], in_valid};
		end
	end

	// light-to-hit and normal unit vectors
	logic signed [16:0] d_in [3];
	logic signed [15:0] n_in [3];
	logic signed [15:0] lpd  [3];
	logic signed [15:0] nu   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_in[i] = 17'($signed(hit_position[16*i +: 16]))
				- 17'($signed(light_position[16*i +: 16]));
			n_in[i] = $signed(surface_normal[16*i +: 16]);
		end
	end

	lpps_unit3 #(.W(17)) u_lpd (.clk(clk), .en(en), .vec(d_in), .unit_vec(lpd));
	lpps_unit3 #(.W(16)) u_nrm (.clk(clk), .en(en), .vec(n_in), .unit_vec(nu));

	side_t side_l1 [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_l1[0] <= '{view: view_direction, light: light_rgb, inten: light_intensity,
				surf: surface_rgb, spec: specular_strength, shade: shade_factor,
				emit: is_emitter};
			for (int k = 1; k < UNIT_LAT; k++)
				side_l1[k] <= side_l1[k-1];
		end
	end

	// stage 1: Lpd . N
	logic signed [15:0] lpd_s1 [3];
	logic signed [15:0] nu_s1  [3];
	logic signed [16:0] dot_s1;
	side_t              side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lpd_s1  <= lpd;
			nu_s1   <= nu;
			dot_s1  <= 17'(rnd_s(64'(lpd[0] * nu[0]) + 64'(lpd[1] * nu[1])
				+ 64'(lpd[2] * nu[2]), 6'd14));
			side_s1 <= side_l1[UNIT_LAT-1];
		end
	end

	// reflection: L = -Lpd and L.N = -dot, so R = -Lpd + 2*dot*N
	logic signed [17:0] r_in [3];
	logic signed [15:0] ru   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_in[i] = -(18'(lpd_s1[i]))
				+ 18'(rnd_s(64'(dot_s1) * 64'(nu_s1[i]) * 64'sd2, 6'd14));
		end
	end

	lpps_unit3 #(.W(18)) u_rfl (.clk(clk), .en(en), .vec(r_in), .unit_vec(ru));

	side_t              side_l2 [UNIT_LAT];
	logic signed [16:0] dot_l2  [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_l2[0] <= side_s1;
			dot_l2[0]  <= dot_s1;
			for (int k = 1; k < UNIT_LAT; k++) begin
				side_l2[k] <= side_l2[k-1];
				dot_l2[k]  <= dot_l2[k-1];
			end
		end
	end

	// stage 2: view . R and diffuse factor
	logic signed [63:0] c_cmb;
	logic               on_cmb;
	logic [16:0]        cp_s2;
	logic signed [19:0] a_s2;
	logic               on_s2;
	side_t              side_s2;

	always_comb begin
		c_cmb = rnd_s(64'($signed(side_l2[UNIT_LAT-1].view[15:0])) * 64'(ru[0])
			+ 64'($signed(side_l2[UNIT_LAT-1].view[31:16])) * 64'(ru[1])
			+ 64'($signed(side_l2[UNIT_LAT-1].view[47:32])) * 64'(ru[2]), 6'd14);
		on_cmb = !side_l2[UNIT_LAT-1].emit && (c_cmb > 64'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2   <= on_cmb ? c_cmb[16:0] : '0;
			on_s2   <= on_cmb;
			a_s2    <= 20'(rnd_s(64'(dot_l2[UNIT_LAT-1])
				* 64'($signed({1'b0, side_l2[UNIT_LAT-1].shade})), 6'd14));
			side_s2 <= side_l2[UNIT_LAT-1];
		end
	end

	// stage 3: c^SHININESS, one rounded multiply per stage
	logic [31:0]        pw_s3   [SHININESS];
	logic [16:0]        cp_s3   [SHININESS];
	logic signed [19:0] a_s3    [SHININESS];
	logic               on_s3   [SHININESS];
	side_t              side_s3 [SHININESS];

	for (genvar k = 0; k < SHININESS; k++) begin : g_pow
		logic [31:0]        p_in;
		logic [16:0]        cp_in;
		logic signed [19:0] a_in;
		logic               on_in;
		side_t              side_in;
		logic [63:0]        t;
		if (k == 0) begin : g_first
			assign p_in    = 32'(Q14_ONE);
			assign cp_in   = cp_s2;
			assign a_in    = a_s2;
			assign on_in   = on_s2;
			assign side_in = side_s2;
		end else begin : g_next
			assign p_in    = pw_s3[k-1];
			assign cp_in   = cp_s3[k-1];
			assign a_in    = a_s3[k-1];
			assign on_in   = on_s3[k-1];
			assign side_in = side_s3[k-1];
		end
		assign t = rnd_u(64'(p_in) * 64'(cp_in), 6'd14);
		always_ff @(posedge clk) begin
			if (en) begin
				pw_s3[k]   <= (t > POW_CAP) ? POW_CAP[31:0] : t[31:0];
				cp_s3[k]   <= cp_in;
				a_s3[k]    <= a_in;
				on_s3[k]   <= on_in;
				side_s3[k] <= side_in;
			end
		end
	end

	// stages 4..7: specular scale, diffuse base, sum and saturate
	logic [33:0]        sp1_s4;
	logic signed [22:0] s_s4 [3];
	logic [47:0]        light_s4;
	logic [15:0]        inten_s4;
	logic [15:0]        shade_s4;
	logic               on_s4;
	logic [34:0]        sp_s5;
	logic signed [27:0] acc_s5 [3];
	logic [47:0]        light_s5;
	logic               on_s5;
	logic [36:0]        term_s6 [3];
	logic signed [27:0] acc_s6  [3];
	logic [47:0]        rgb_s7;
	logic signed [38:0] sum [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			sum[i] = 39'(acc_s6[i]) + $signed({2'b00, term_s6[i]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp1_s4 <= 34'(rnd_u(64'(pw_s3[SHININESS-1])
				* 64'(side_s3[SHININESS-1].spec), 6'd14));
			for (int i = 0; i < 3; i++) begin
				s_s4[i] <= 23'(64'($signed({1'b0, side_s3[SHININESS-1].surf[16*i +: 16]}))
					+ rnd_s(64'($signed({1'b0, side_s3[SHININESS-1].light[16*i +: 16]}))
					* 64'(a_s3[SHININESS-1]), 6'd14));
			end
			light_s4 <= side_s3[SHININESS-1].light;
			inten_s4 <= side_s3[SHININESS-1].inten;
			shade_s4 <= side_s3[SHININESS-1].shade;
			on_s4    <= on_s3[SHININESS-1];

			sp_s5 <= 35'(rnd_u(64'(sp1_s4) * 64'(shade_s4), 6'd14));
			for (int i = 0; i < 3; i++)
				acc_s5[i] <= 28'(rnd_s(64'(s_s4[i]) * 64'($signed({1'b0, inten_s4})), 6'd13));
			light_s5 <= light_s4;
			on_s5    <= on_s4;

			for (int i = 0; i < 3; i++) begin
				term_s6[i] <= on_s5 ? 37'(rnd_u(64'(light_s5[16*i +: 16]) * 64'(sp_s5), 6'd14))
					: '0;
				acc_s6[i]  <= acc_s5[i];
			end

			for (int i = 0; i < 3; i++) begin
				if (sum[i] < 39'sd0)
					rgb_s7[16*i +: 16] <= '0;
				else if (sum[i] > 39'sd65535)
					rgb_s7[16*i +: 16] <= 16'hFFFF;
				else
					rgb_s7[16*i +: 16] <= sum[i][15:0];
			end
		end
	end

	assign shaded_rgb = rgb_s7;

endmodule

FILE: bench/shade_checker.sv
`timescale 1ns / 100ps
module shade_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [47:0] hit_position,
	input  logic [47:0] surface_normal,
	input  logic [47:0] view_direction,
	input  logic [47:0] light_position,
	input  logic [47:0] light_rgb,
	input  logic [15:0] light_intensity,
	input  logic [47:0] surface_rgb,
	input  logic [15:0] specular_strength,
	input  logic [15:0] shade_factor,
	input  logic        is_emitter,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [47:0] shaded_rgb,
	output int          errors,
	output int          pending
);

	localparam int SHINE = 20;
	localparam longint ONE = 16384;
	localparam longint CAP = 64'sd2147483648;

	logic [47:0] color_q[$];

	assign pending = color_q.size();

	function automatic longint sfield(input logic [47:0] v, input int i);
		return longint'($signed(v[16*i +: 16]));
	endfunction

	function automatic longint div_near(input longint num, input longint den);
		longint mag;
		longint q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return div_near(a * b, ONE);
	endfunction

	function automatic longint floor_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic void normalize(input longint c[3], output longint u[3]);
		logic [63:0] s;
		longint len;
		longint q;
		s = 0;
		for (int i = 0; i < 3; i++)
			s = s + 64'(c[i] * c[i]);
		if (s == 0) begin
			u = '{0, 0, 0};
			return;
		end
		len = floor_sqrt(s << 28);
		for (int i = 0; i < 3; i++) begin
			q = div_near(c[i] * 268435456, len);
			if (q > ONE) q = ONE;
			if (q < -ONE) q = -ONE;
			u[i] = q;
		end
	endfunction

	function automatic longint dot3(input longint a[3], input longint b[3]);
		return div_near(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], ONE);
	endfunction

	function automatic logic [47:0] shade_hit();
		longint d[3], nr[3], vw[3], lpd[3], nu[3], lu[3], rr[3], ru[3], acc[3];
		longint a, ln, c, p, sp, s, v;
		logic [47:0] res;
		for (int i = 0; i < 3; i++) begin
			d[i] = sfield(hit_position, i) - sfield(light_position, i);
			nr[i] = sfield(surface_normal, i);
			vw[i] = sfield(view_direction, i);
		end
		normalize(d, lpd);
		normalize(nr, nu);
		a = qmul(dot3(lpd, nu), longint'(shade_factor));
		for (int i = 0; i < 3; i++) begin
			s = longint'(surface_rgb[16*i +: 16]) + qmul(longint'(light_rgb[16*i +: 16]), a);
			acc[i] = div_near(s * longint'(light_intensity), 8192);
		end
		if (!is_emitter) begin
			for (int i = 0; i < 3; i++)
				lu[i] = -lpd[i];
			ln = dot3(lu, nu);
			for (int i = 0; i < 3; i++)
				rr[i] = lu[i] - div_near(2 * ln * nu[i], ONE);
			normalize(rr, ru);
			c = dot3(vw, ru);
			if (c > 0) begin
				p = ONE;
				for (int k = 0; k < SHINE; k++) begin
					p = qmul(p, c);
					if (p > CAP) p = CAP;
				end
				sp = qmul(qmul(p, longint'(specular_strength)), longint'(shade_factor));
				for (int i = 0; i < 3; i++)
					acc[i] = acc[i] + qmul(longint'(light_rgb[16*i +: 16]), sp);
			end
		end
		for (int i = 0; i < 3; i++) begin
			v = acc[i];
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
			res[16*i +: 16] = v[15:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [47:0] want;
		int bad;
		if (!arst_n) begin
			errors <= 0;
			color_q.delete();
		end else begin
			bad = 0;
			if (in_valid && in_ready)
				color_q.push_back(shade_hit());
			if (out_valid && out_ready) begin
				if (color_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, shaded_rgb);
					bad = bad + 1;
				end else begin
					want = color_q.pop_front();
					for (int i = 0; i < 3; i++)
						if (want[16*i +: 16] !== shaded_rgb[16*i +: 16]) begin
							$display("%0t: channel %0d expected %h actual %h", $time, i,
								want[16*i +: 16], shaded_rgb[16*i +: 16]);
							bad = bad + 1;
						end
				end
			end
			errors <= errors + bad;
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;

	localparam int LATENCY = 78;
	localparam int WATCH_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [47:0] hit_position;
	logic [47:0] surface_normal;
	logic [47:0] view_direction;
	logic [47:0] light_position;
	logic [47:0] light_rgb;
	logic [15:0] light_intensity;
	logic [47:0] surface_rgb;
	logic [15:0] specular_strength;
	logic [15:0] shade_factor;
	logic        is_emitter;
	logic        out_valid;
	logic        out_ready;
	logic [47:0] shaded_rgb;
	int          errors;
	int          pending;
	int          send_idle;
	int          recv_idle;
	int          quiet;

	lambert_phong_point_shader DUT (.*);

	shade_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [15:0] small_pos();
		return 16'($signed($urandom_range(1200)) - 600);
	endfunction

	// one request; payload held until accepted, valid left high for a follow-on request
	task automatic send_hit(input logic [47:0] hp, nrm, vd, lp, lc,
		input logic [15:0] li, input logic [47:0] sc,
		input logic [15:0] sk, sh, input logic em);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hit_position <= hp;
		surface_normal <= nrm;
		view_direction <= vd;
		light_position <= lp;
		light_rgb <= lc;
		light_intensity <= li;
		surface_rgb <= sc;
		specular_strength <= sk;
		shade_factor <= sh;
		is_emitter <= em;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mostly plausible scenes: lights near the hit, unit-ish normals, moderate colors
	task automatic send_random();
		if ($urandom_range(9) < 2)
			send_hit(rand48(), rand48(), rand48(), rand48(), rand48(),
				16'($urandom), rand48(), 16'($urandom), 16'($urandom), 1'($urandom));
		else
			send_hit({small_pos(), small_pos(), small_pos()},
				{small_pos() << 5, small_pos() << 5, small_pos() << 5},
				{small_pos() << 5, small_pos() << 5, small_pos() << 5},
				{small_pos(), small_pos(), small_pos()},
				{16'($urandom_range(20000)), 16'($urandom_range(20000)),
					16'($urandom_range(20000))},
				16'($urandom_range(8192)),
				{16'($urandom_range(20000)), 16'($urandom_range(20000)),
					16'($urandom_range(20000))},
				16'($urandom_range(16384)), 16'($urandom_range(16384)), 1'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [47:0] zp;
		arst_n = 1'b0;
		in_valid = 1'b0;
		hit_position = '0;
		surface_normal = '0;
		view_direction = '0;
		light_position = '0;
		light_rgb = '0;
		light_intensity = '0;
		surface_rgb = '0;
		specular_strength = '0;
		shade_factor = '0;
		is_emitter = 1'b0;
		out_ready = 1'b0;
		quiet = 0;
		send_idle = 9;
		recv_idle = 66;
		zp = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// mirror reflection straight back at viewer: strongest specular
		send_hit({16'd0, 16'd0, 16'd0}, {16'd16384, 16'd0, 16'd0},
			{16'hC000, 16'd0, 16'd0}, {16'd640, 16'd0, 16'd0},
			{3{16'hFFFF}}, 16'hFFFF, {3{16'hFFFF}}, 16'hFFFF, 16'hFFFF, 1'b0);
		// same light and view with another normal, emitter
		send_hit(zp, {16'd0, 16'd0, 16'd16384}, {16'hC000, 16'd0, 16'd0},
			{16'd640, 16'd0, 16'd0}, {3{16'hFFFF}}, 16'hFFFF, {3{16'hFFFF}},
			16'hFFFF, 16'hFFFF, 1'b1);
		// hit and light coincide
		send_hit({16'd100, 16'd200, 16'hFF00}, {16'd0, 16'd16384, 16'd0}, rand48(),
			{16'd100, 16'd200, 16'hFF00}, {3{16'd16384}}, 16'd4096,
			{3{16'd8192}}, 16'd16384, 16'd16384, 1'b0);
		// zero normal
		send_hit(zp, zp, {16'd0, 16'd16384, 16'd0}, {16'd0, 16'd640, 16'd0},
			{3{16'd16384}}, 16'd4096, {3{16'd8192}}, 16'd16384, 16'd16384, 1'b0);
		// back-facing light: specular off, diffuse saturates to full scale
		send_hit(zp, {16'd0, 16'd16384, 16'd0}, {16'd0, 16'hC000, 16'd0},
			{16'd0, 16'hFD80, 16'd0}, {3{16'hFFFF}}, 16'hFFFF, {3{16'd0}},
			16'd0, 16'hFFFF, 1'b0);
		// extreme coordinates and all-ones / all-zeros fields
		send_hit({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
			{3{16'hFFFF}}, 16'hFFFF, {3{16'hFFFF}}, 16'hFFFF, 16'hFFFF, 1'b0);
		send_hit({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
			'0, 16'd0, '0, 16'd0, 16'd0, 1'b0);
		send_hit({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'h0001}},
			{3{16'h8000}}, 16'h8000, {3{16'h8000}}, 16'h8000, 16'h8000, 1'b1);
		repeat (12) send_random();
		// pause until the pipe is empty
		drain();
		repeat (3) @(posedge clk);
		repeat (560) send_random();
		send_idle = 66;
		recv_idle = 9;
		repeat (560) send_random();
		send_idle = 0;
		recv_idle = 0;
		repeat (600) send_random();
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
hdl/lpps_pkg.sv
hdl/lpps_unit3.sv
hdl/lambert_phong_point_shader.sv
bench/shade_checker.sv
bench/testbench.sv
